// ----- sv/ttp_pkg.sv -----
// ttp_pkg: shared types, widths, function codes and Q.30 coefficient tables
// for the Taylor polynomial evaluator; no dependencies
package ttp_pkg;

    localparam int IFRAC   = 30;
    localparam int XW      = 33;
    localparam int ACC_W   = 55;
    localparam int MAG_W   = 54;
    localparam int HALF_W  = 27;
    localparam int MUL_W   = 35;
    localparam int VAL_W   = 32;
    localparam int NCOEF   = 8;
    localparam int NCELL   = 9;
    localparam int CELL_LAT = 4;
    localparam int RND_LAT  = 3;
    localparam int LATENCY  = 1 + NCELL * CELL_LAT + RND_LAT;

    localparam logic [1:0] OP_SIN  = 2'd0;
    localparam logic [1:0] OP_COS  = 2'd1;
    localparam logic [1:0] OP_TAN  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic [1:0]       op;
        logic             x_neg;
        logic [XW-1:0]    x_mag;
        logic [MUL_W-1:0] y;
    } t_side;

    typedef struct packed {
        logic  valid;
        t_side side;
    } t_beat;

    localparam logic [63:0] ONE_SH = 64'd1 << IFRAC;
    localparam logic [MUL_W-1:0] ONE_MUL = MUL_W'(ONE_SH);

    localparam t_acc QC_ONE = t_acc'(ONE_SH);
    localparam t_acc QC_F2  = t_acc'((ONE_SH + 64'd2 / 64'd2) / 64'd2);
    localparam t_acc QC_F3  = t_acc'((ONE_SH + 64'd6 / 64'd2) / 64'd6);
    localparam t_acc QC_F4  = t_acc'((ONE_SH + 64'd24 / 64'd2) / 64'd24);
    localparam t_acc QC_F5  = t_acc'((ONE_SH + 64'd120 / 64'd2) / 64'd120);
    localparam t_acc QC_F6  = t_acc'((ONE_SH + 64'd720 / 64'd2) / 64'd720);
    localparam t_acc QC_F7  = t_acc'((ONE_SH + 64'd5040 / 64'd2) / 64'd5040);
    localparam t_acc QC_F8  = t_acc'((ONE_SH + 64'd40320 / 64'd2) / 64'd40320);
    localparam t_acc QC_F9  = t_acc'((ONE_SH + 64'd362880 / 64'd2) / 64'd362880);
    localparam t_acc QC_F10 = t_acc'((ONE_SH + 64'd3628800 / 64'd2) / 64'd3628800);
    localparam t_acc QC_F11 = t_acc'((ONE_SH + 64'd39916800 / 64'd2) / 64'd39916800);
    localparam t_acc QC_F12 = t_acc'((ONE_SH + 64'd479001600 / 64'd2) / 64'd479001600);

    localparam t_acc QC_T3  = t_acc'((ONE_SH + 64'd3 / 64'd2) / 64'd3);
    localparam t_acc QC_T5  = t_acc'((64'd2 * ONE_SH + 64'd15 / 64'd2) / 64'd15);
    localparam t_acc QC_T7  = t_acc'((64'd17 * ONE_SH + 64'd315 / 64'd2) / 64'd315);
    localparam t_acc QC_T9  = t_acc'((64'd62 * ONE_SH + 64'd2835 / 64'd2) / 64'd2835);
    localparam t_acc QC_T11 =
        t_acc'((64'd1382 * ONE_SH + 64'd155925 / 64'd2) / 64'd155925);
    localparam t_acc QC_T13 =
        t_acc'((64'd21844 * ONE_SH + 64'd6081075 / 64'd2) / 64'd6081075);
    localparam t_acc QC_T15 =
        t_acc'((64'd929569 * ONE_SH + 64'd638512875 / 64'd2) / 64'd638512875);

    typedef t_acc t_coef_row [NCOEF];

    // highest degree first, shorter series padded with leading zeros
    localparam t_coef_row SIN_COEF = '{
        t_acc'(0), t_acc'(0), -QC_F11, QC_F9, -QC_F7, QC_F5, -QC_F3, QC_ONE
    };
    localparam t_coef_row COS_COEF = '{
        t_acc'(0), QC_F12, -QC_F10, QC_F8, -QC_F6, QC_F4, -QC_F2, QC_ONE
    };
    localparam t_coef_row TAN_COEF = '{
        QC_T15, QC_T13, QC_T11, QC_T9, QC_T7, QC_T5, QC_T3, QC_ONE
    };

    function automatic t_acc coef_of(input logic [1:0] op, input logic [2:0] k);
        unique case (op)
            OP_SIN:  coef_of = SIN_COEF[k];
            OP_COS:  coef_of = COS_COEF[k];
            OP_TAN:  coef_of = TAN_COEF[k];
            default: coef_of = t_acc'(0);
        endcase
    endfunction

endpackage

// ----- sv/ttp_cell.sv -----
// ttp_cell: one multiply-accumulate cell of the chain, acc * mul + coef in Q.30
// with round to nearest, ties away from zero; four stages; depends on ttp_pkg
module ttp_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ttp_pkg::t_beat              i_beat,
    input  ttp_pkg::t_acc               i_acc,
    input  logic [ttp_pkg::MUL_W-1:0]   i_mul,
    input  logic                        i_mul_neg,
    input  ttp_pkg::t_acc               i_coef,
    output ttp_pkg::t_beat              o_beat,
    output ttp_pkg::t_acc               o_acc
);

    localparam int MAG_W  = ttp_pkg::MAG_W;
    localparam int HALF_W = ttp_pkg::HALF_W;
    localparam int MUL_W  = ttp_pkg::MUL_W;
    localparam int ACC_W  = ttp_pkg::ACC_W;
    localparam int PP_W   = HALF_W + MUL_W;
    localparam int PH_W   = MAG_W - HALF_W + MUL_W;
    localparam int SUM_W  = MAG_W + MUL_W + 1;

    logic r1_vld, r2_vld, r3_vld, r4_vld;
    ttp_pkg::t_side r1_side, r2_side, r3_side, r4_side;

    logic [MAG_W-1:0]  r1_mag;
    logic              r1_neg, r2_neg, r3_neg;
    logic [MUL_W-1:0]  r1_mul;
    ttp_pkg::t_acc     r1_coef, r2_coef, r3_coef;
    logic [PP_W-1:0]   r2_plo;
    logic [PH_W-1:0]   r2_phi;
    logic [MAG_W-1:0]  r3_rnd;
    ttp_pkg::t_acc     r4_acc;

    logic [MAG_W-1:0]  n_mag;
    logic [SUM_W-1:0]  n_sum;
    ttp_pkg::t_acc     n_acc;

    assign n_mag = i_acc[ACC_W-1] ? MAG_W'(-i_acc) : MAG_W'(i_acc);

    assign n_sum = SUM_W'({r2_phi, {HALF_W{1'b0}}}) + SUM_W'(r2_plo)
                 + (SUM_W'(1) << (ttp_pkg::IFRAC - 1));

    // sign applied as invert plus carry in, folded into the coefficient add
    assign n_acc = r3_coef + ttp_pkg::t_acc'({1'b0, r3_rnd} ^ {ACC_W{r3_neg}})
                 + ttp_pkg::t_acc'(r3_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_beat.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side <= i_beat.side;
        r1_mag  <= n_mag;
        r1_neg  <= i_acc[ACC_W-1] ^ i_mul_neg;
        r1_mul  <= i_mul;
        r1_coef <= i_coef;

        r2_side <= r1_side;
        r2_plo  <= PP_W'(r1_mag[HALF_W-1:0]) * PP_W'(r1_mul);
        r2_phi  <= PH_W'(r1_mag[MAG_W-1:HALF_W]) * PH_W'(r1_mul);
        r2_neg  <= r1_neg;
        r2_coef <= r1_coef;

        r3_side <= r2_side;
        r3_rnd  <= n_sum[ttp_pkg::IFRAC +: MAG_W];
        r3_neg  <= r2_neg;
        r3_coef <= r2_coef;

        r4_side <= r3_side;
        r4_acc  <= n_acc;
    end

    assign o_beat = '{valid: r4_vld, side: r4_side};
    assign o_acc  = r4_acc;

endmodule

// ----- sv/ttp_round.sv -----
// ttp_round: scales the Q.30 result to the output format, rounds, saturates, zeroes OP_NONE beats
// and registers the result beat; three stages; depends on ttp_pkg
module ttp_round #(
    parameter int FRAC_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ttp_pkg::t_beat                  i_beat,
    input  ttp_pkg::t_acc                   i_acc,
    output logic                            o_strobe,
    output logic signed [ttp_pkg::VAL_W-1:0] o_value,
    output logic                            o_saturated
);

    localparam int MAG_W = ttp_pkg::MAG_W;
    localparam int VAL_W = ttp_pkg::VAL_W;
    localparam int SH    = ttp_pkg::IFRAC - FRAC_BITS;
    localparam logic [MAG_W:0] RND = (SH > 0) ? ((MAG_W + 1)'(1) << (SH - 1)) : '0;
    localparam logic [MAG_W:0] POS_LIM = (MAG_W + 1)'({1'b0, {(VAL_W - 1){1'b1}}});
    localparam logic [MAG_W:0] NEG_LIM = (MAG_W + 1)'(1) << (VAL_W - 1);
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

    logic             ra_vld, rb_vld;
    logic             ra_neg, rb_neg;
    logic             ra_none, rb_none;
    logic [MAG_W-1:0] ra_mag;
    logic [MAG_W:0]   rb_m;
    logic             r_strobe;
    logic signed [VAL_W-1:0] r_value;
    logic             r_sat;

    logic [MAG_W:0]   n_m;
    logic signed [VAL_W-1:0] n_value;
    logic             n_sat;

    assign n_m = ({1'b0, ra_mag} + RND) >> SH;

    always_comb begin
        n_value = rb_neg ? -$signed(rb_m[VAL_W-1:0]) : $signed(rb_m[VAL_W-1:0]);
        n_sat   = 1'b0;
        if (rb_none) begin
            n_value = '0;
        end else if (!rb_neg && rb_m > POS_LIM) begin
            n_value = VAL_MAX;
            n_sat   = 1'b1;
        end else if (rb_neg && rb_m > NEG_LIM) begin
            n_value = VAL_MIN;
            n_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld   <= 1'b0;
            rb_vld   <= 1'b0;
            r_strobe <= 1'b0;
            r_sat    <= 1'b0;
        end else begin
            ra_vld   <= i_beat.valid;
            rb_vld   <= ra_vld;
            r_strobe <= rb_vld;
            r_sat    <= rb_vld & n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        ra_neg  <= i_acc[ttp_pkg::ACC_W-1];
        ra_mag  <= i_acc[ttp_pkg::ACC_W-1] ? MAG_W'(-i_acc) : MAG_W'(i_acc);
        ra_none <= (i_beat.side.op == ttp_pkg::OP_NONE);
        rb_neg  <= ra_neg;
        rb_none <= ra_none;
        rb_m    <= n_m;
        r_value <= n_value;
    end

    assign o_strobe    = r_strobe;
    assign o_value     = r_value;
    assign o_saturated = r_sat;

`ifndef NO_ASSERTIONS
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> (o_value == VAL_MAX || o_value == VAL_MIN))
        else $error("saturated beat without a limit value");
`endif

endmodule

// ----- sv/trig_taylor_polynomial.sv -----
// trig_taylor_polynomial: sine, cosine or tangent of a Q2.30 angle by Horner
// evaluation of a truncated Taylor series; uses ttp_pkg, ttp_cell, ttp_round
//
//   channel | ports                        | handshake
//   --------+------------------------------+-----------------------------------
//   in      | start, busy, i_op, i_angle   | beat taken when start & !busy
//   out     | o_strobe, o_value, o_saturated | one cycle per beat, no back-pressure
//
// One angle per cycle while busy is low; from accept to strobe a beat passes an
// input register, nine four-stage multiply cells (square, seven Horner steps,
// final multiply by the angle) and three rounding stages.
// Reset clears all valid flags and drops any beats in flight; busy is high
// only during reset and the cycle after it.
// The receiver cannot stall, so results leave in accept order at fixed latency.
module trig_taylor_polynomial #(
    parameter int FRAC_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_op,
    input  logic signed [ttp_pkg::XW-1:0]   i_angle,
    output logic                            o_strobe,
    output logic signed [ttp_pkg::VAL_W-1:0] o_value,
    output logic                            o_saturated
);

    localparam int NCELL = ttp_pkg::NCELL;
    localparam int XW    = ttp_pkg::XW;
    localparam int MUL_W = ttp_pkg::MUL_W;

    logic                   r_ready;
    logic                   r_in_vld;
    logic [1:0]             r_op;
    logic signed [XW-1:0]   r_angle;
    logic [XW-1:0]          x_mag;
    logic                   accept;

    ttp_pkg::t_beat         w_in_beat [NCELL];
    ttp_pkg::t_acc          w_in_acc  [NCELL];
    logic [MUL_W-1:0]       w_mul     [NCELL];
    logic                   w_mul_neg [NCELL];
    ttp_pkg::t_acc          w_coef    [NCELL];
    ttp_pkg::t_beat         w_out_beat[NCELL];
    ttp_pkg::t_acc          w_out_acc [NCELL];

    assign busy   = !r_ready || !i_rst_n;
    assign accept = start && !busy;
    assign x_mag  = r_angle[XW-1] ? XW'(-r_angle) : XW'(r_angle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_in_vld <= 1'b0;
        end else begin
            r_ready  <= 1'b1;
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= i_op;
        r_angle <= i_angle;
    end

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        if (g == 0) begin : g_square
            assign w_in_beat[g] = '{valid: r_in_vld,
                                   side: '{op: r_op, x_neg: r_angle[XW-1],
                                           x_mag: x_mag, y: '0}};
            assign w_in_acc[g]  = ttp_pkg::t_acc'(r_angle);
            assign w_mul[g]     = MUL_W'(x_mag);
            assign w_mul_neg[g] = r_angle[XW-1];
            assign w_coef[g]    = ttp_pkg::t_acc'(0);
        end else if (g == 1) begin : g_first
            always_comb begin
                w_in_beat[g]         = w_out_beat[g-1];
                w_in_beat[g].side.y  = w_out_acc[g-1][MUL_W-1:0];
            end
            assign w_in_acc[g]  = ttp_pkg::coef_of(w_out_beat[g-1].side.op, 3'd0);
            assign w_mul[g]     = w_in_beat[g].side.y;
            assign w_mul_neg[g] = 1'b0;
            assign w_coef[g]    = ttp_pkg::coef_of(w_in_beat[g].side.op, 3'(g));
        end else if (g < NCELL - 1) begin : g_horner
            assign w_in_beat[g] = w_out_beat[g-1];
            assign w_in_acc[g]  = w_out_acc[g-1];
            assign w_mul[g]     = w_in_beat[g].side.y;
            assign w_mul_neg[g] = 1'b0;
            assign w_coef[g]    = ttp_pkg::coef_of(w_in_beat[g].side.op, 3'(g));
        end else begin : g_odd
            // cosine multiplies by one, sine and tangent by the angle
            assign w_in_beat[g] = w_out_beat[g-1];
            assign w_in_acc[g]  = w_out_acc[g-1];
            assign w_mul[g]     = (w_in_beat[g].side.op == ttp_pkg::OP_COS)
                                ? ttp_pkg::ONE_MUL : MUL_W'(w_in_beat[g].side.x_mag);
            assign w_mul_neg[g] = (w_in_beat[g].side.op != ttp_pkg::OP_COS)
                                && w_in_beat[g].side.x_neg;
            assign w_coef[g]    = ttp_pkg::t_acc'(0);
        end

        ttp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_beat    (w_in_beat[g]),
            .i_acc     (w_in_acc[g]),
            .i_mul     (w_mul[g]),
            .i_mul_neg (w_mul_neg[g]),
            .i_coef    (w_coef[g]),
            .o_beat    (w_out_beat[g]),
            .o_acc     (w_out_acc[g])
        );
    end

    ttp_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (w_out_beat[NCELL-1]),
        .i_acc       (w_out_acc[NCELL-1]),
        .o_strobe    (o_strobe),
        .o_value     (o_value),
        .o_saturated (o_saturated)
    );

`ifndef NO_ASSERTIONS
    a_strobe_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(ttp_pkg::LATENCY) o_strobe)
        else $error("accepted beat did not come out at fixed latency");

    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, ttp_pkg::LATENCY))
        else $error("result beat without a matching accepted beat");

    a_square_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat[0].valid |-> !w_out_acc[0][ttp_pkg::ACC_W-1])
        else $error("squared angle came out negative");

    a_sat_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> o_strobe)
        else $error("saturation flag outside a result beat");
`endif

endmodule

// ----- test/tb_trig_taylor_polynomial.sv -----
// tb_trig_taylor_polynomial: self-checking bench for the sine/cosine/tangent Taylor
// evaluator; a scoreboard class predicts each beat in Q.30 and checks the strobed result
// depends on ttp_pkg and trig_taylor_polynomial
module tb_trig_taylor_polynomial;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IFRAC        = ttp_pkg::IFRAC;
    localparam int XW           = ttp_pkg::XW;
    localparam int VAL_W        = ttp_pkg::VAL_W;
    localparam int LATENCY      = ttp_pkg::LATENCY;
    localparam int FRAC_BITS    = 24;
    localparam int RND_SH       = IFRAC - FRAC_BITS;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [XW-1:0] ANG_MAX = 33'sh0_FFFF_FFFF;
    localparam logic signed [XW-1:0] ANG_MIN = 33'sh1_0000_0000;
    localparam logic signed [XW-1:0] ANG_ONE = 33'sh0_4000_0000;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    saturated;
    } t_trig_result;

    class taylor_scoreboard;
        t_trig_result pending_results[$];
        longint       series[3][8];
        int           mismatches;

        function new();
            mismatches = 0;
            series[ttp_pkg::OP_SIN] = '{0, 0, -q30_coef(1, 39916800), q30_coef(1, 362880),
                               -q30_coef(1, 5040), q30_coef(1, 120), -q30_coef(1, 6),
                               q30_coef(1, 1)};
            series[ttp_pkg::OP_COS] = '{0, q30_coef(1, 479001600), -q30_coef(1, 3628800),
                               q30_coef(1, 40320), -q30_coef(1, 720), q30_coef(1, 24),
                               -q30_coef(1, 2), q30_coef(1, 1)};
            series[ttp_pkg::OP_TAN] = '{q30_coef(929569, 638512875),
                               q30_coef(21844, 6081075),
                               q30_coef(1382, 155925), q30_coef(62, 2835),
                               q30_coef(17, 315), q30_coef(2, 15), q30_coef(1, 3),
                               q30_coef(1, 1)};
        endfunction

        static function longint q30_coef(longint unsigned num, longint unsigned den);
            return longint'(((num << IFRAC) + den / 2) / den);
        endfunction

        // exact product, rounded half away from zero, clamped to the 64-bit range
        static function longint q30_mul(longint a, longint b);
            bit                  neg;
            bit [63:0]           ua;
            bit [63:0]           ub;
            bit [127:0]          prod;
            bit [63:0]           r;
            neg  = (a < 0) != (b < 0);
            ua   = (a < 0) ? 64'(-a) : 64'(a);
            ub   = (b < 0) ? 64'(-b) : 64'(b);
            prod = {64'd0, ua} * {64'd0, ub};
            prod = prod + (128'd1 << (IFRAC - 1));
            if (prod[127:93] != '0)
                r = 64'h7FFF_FFFF_FFFF_FFFF;
            else
                r = {1'b0, prod[92:IFRAC]};
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function t_trig_result taylor_eval(logic [1:0] op, logic signed [XW-1:0] ang);
            longint          x;
            longint          y;
            longint          acc;
            longint          q;
            longint          v;
            longint unsigned m;
            bit              neg;
            int              k;
            t_trig_result    r;
            r.value     = '0;
            r.saturated = 1'b0;
            if (op == ttp_pkg::OP_NONE)
                return r;
            x   = longint'(ang);
            y   = q30_mul(x, x);
            acc = 0;
            for (k = 0; k < 8; k++)
                acc = q30_mul(acc, y) + series[op][k];
            q   = (op == ttp_pkg::OP_COS) ? acc : q30_mul(acc, x);
            neg = q < 0;
            m   = neg ? 64'(-q) : 64'(q);
            if (RND_SH > 0)
                m = (m + (64'd1 << (RND_SH - 1))) >> RND_SH;
            if (!neg && m > 64'h7FFF_FFFF) begin
                m           = 64'h7FFF_FFFF;
                r.saturated = 1'b1;
            end else if (neg && m > 64'h8000_0000) begin
                m           = 64'h8000_0000;
                r.saturated = 1'b1;
            end
            v       = neg ? -longint'(m) : longint'(m);
            r.value = v[VAL_W-1:0];
            return r;
        endfunction

        function void note_angle(logic [1:0] op, logic signed [XW-1:0] ang);
            pending_results.push_back(taylor_eval(op, ang));
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic signed [VAL_W-1:0] value, logic saturated);
            t_trig_result want;
            if (pending_results.size() == 0) begin
                flag($sformatf("unexpected result value=%0d saturated=%0b",
                               value, saturated));
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value)
                flag($sformatf("value mismatch: expected %0d, got %0d",
                               want.value, value));
            if (saturated !== want.saturated)
                flag($sformatf("saturated mismatch: expected %0b, got %0b",
                               want.saturated, saturated));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_op;
    logic signed [XW-1:0]    i_angle;
    logic                    o_strobe;
    logic signed [VAL_W-1:0] o_value;
    logic                    o_saturated;

    int                      quiet_cycles = 0;
    taylor_scoreboard        sb = new();

    trig_taylor_polynomial #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_angle    (i_angle),
        .o_strobe   (o_strobe),
        .o_value    (o_value),
        .o_saturated(o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_angle(i_op, i_angle);
        if (i_rst_n && o_strobe)
            sb.check_result(o_value, o_saturated);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_trig_taylor_polynomial: FAIL");
            $finish;
        end
    end

    task automatic issue_angle(input logic [1:0] op, input logic signed [XW-1:0] ang);
        start   <= 1'b1;
        i_op    <= op;
        i_angle <= ang;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic signed [XW-1:0] random_angle();
        logic signed [XW-1:0] ang;
        case ($urandom_range(0, 3))
            0: ang = {1'($urandom_range(0, 1)), 32'($urandom())};
            1: ang = 33'($signed(32'($urandom())));
            2: begin
                ang = 33'($urandom_range(0, 4095));
                ang = ang - 33'sd2048;
            end
            default: begin
                // outside -2..2, where tangent runs into the clamp
                ang = {2'b01, 31'($urandom())};
                if ($urandom_range(0, 1))
                    ang = -ang;
            end
        endcase
        return ang;
    endfunction

    initial begin
        logic signed [XW-1:0] edge_angles[8];
        logic [1:0]           op;
        int                   sent;
        int                   burst;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_op    <= ttp_pkg::OP_SIN;
        i_angle <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        edge_angles = '{'0, ANG_MAX, ANG_MIN, ANG_ONE, -ANG_ONE, 33'sd1, -33'sd1,
                        33'sd1686629713};
        foreach (edge_angles[j]) begin
            issue_angle(ttp_pkg::OP_SIN, edge_angles[j]);
            issue_angle(ttp_pkg::OP_COS, edge_angles[j]);
            issue_angle(ttp_pkg::OP_TAN, edge_angles[j]);
        end
        issue_angle(ttp_pkg::OP_NONE, ANG_MAX);
        issue_angle(ttp_pkg::OP_NONE, ANG_MIN);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 15));
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                op = ($urandom_range(0, 9) == 0) ? ttp_pkg::OP_NONE
                                                 : 2'($urandom_range(0, 2));
                issue_angle(op, random_angle());
                sent++;
            end
        end
        start <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("tb_trig_taylor_polynomial: PASS");
        else
            $display("tb_trig_taylor_polynomial: FAIL");
        $finish;
    end

endmodule
